### rtl/core/ubx_pkg.sv
// ----------------------------------------------------------------------------
// ubx_pkg
// Shared types and constants of the UBX frame builder: the input and result
// transfer formats, the sync bytes, and the command passed from the front end
// to the back end through the command queue.
// ----------------------------------------------------------------------------
package ubx_pkg;

    // Operation codes of an input item.
    localparam logic OP_START   = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    // Frame sync bytes.
    localparam logic [7:0] SYNC_ONE = 8'hB5;
    localparam logic [7:0] SYNC_TWO = 8'h62;

    // Command kinds in the queue.
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_DATA   = 1'b1;

    // One input transfer.
    typedef struct packed {
        logic        op;
        logic [7:0]  msg_class;
        logic [7:0]  msg_id;
        logic [15:0] payload_length;
        logic [7:0]  payload_byte;
    } ubx_in_t;

    // One result transfer.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
    } ubx_out_t;

    // One command for the serializer. For a header, first is the class byte
    // and second the id byte; for data, first is the payload byte.
    // With tail set, the two checksum bytes follow the command's bytes.
    typedef struct packed {
        logic        kind;
        logic [7:0]  first;
        logic [7:0]  second;
        logic [15:0] length;
        logic [7:0]  ck_a;
        logic [7:0]  ck_b;
        logic        tail;
    } ubx_cmd_t;

    // Handshake between a producer and the command queue.
    typedef struct packed {
        logic     valid;
        ubx_cmd_t cmd;
    } ubx_push_t;

endpackage

### rtl/core/ubx_front.sv
// ----------------------------------------------------------------------------
// ubx_front
// Front end: accepts input items, tracks the frame, keeps the running
// Fletcher sums and turns each item into at most one serializer command.
// ----------------------------------------------------------------------------
module ubx_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  ubx_pkg::ubx_in_t  item_data,
    input  logic              q_full,
    output ubx_pkg::ubx_push_t push
);

    logic [7:0]  sum_a_reg, sum_a_next;
    logic [7:0]  sum_b_reg, sum_b_next;
    logic [15:0] left_reg, left_next;
    logic        in_frame_reg, in_frame_next;

    logic        take;
    logic [7:0]  len_lo, len_hi;
    logic [7:0]  hdr_a1, hdr_a2, hdr_a3, hdr_a4, hdr_b;
    logic [7:0]  dat_a, dat_b;
    logic        len_zero;
    logic        last_byte;

    // An item is taken whenever the queue has room, including dropped ones.
    assign item_ready = !q_full;
    assign take       = item_valid && item_ready;

    // Header checksum over class, id and both length bytes.
    assign len_lo   = item_data.payload_length[7:0];
    assign len_hi   = item_data.payload_length[15:8];
    assign hdr_a1   = item_data.msg_class;
    assign hdr_a2   = hdr_a1 + item_data.msg_id;
    assign hdr_a3   = hdr_a2 + len_lo;
    assign hdr_a4   = hdr_a3 + len_hi;
    assign hdr_b    = hdr_a1 + hdr_a2 + hdr_a3 + hdr_a4;
    assign len_zero = (item_data.payload_length == 16'd0);

    // Running checksum step for one payload byte.
    assign dat_a     = sum_a_reg + item_data.payload_byte;
    assign dat_b     = sum_b_reg + dat_a;
    assign last_byte = (left_reg == 16'd1);

    // Next state and command generation.
    always_comb
    begin
        sum_a_next    = sum_a_reg;
        sum_b_next    = sum_b_reg;
        left_next     = left_reg;
        in_frame_next = in_frame_reg;
        push.valid       = 1'b0;
        push.cmd.kind    = ubx_pkg::KIND_HEADER;
        push.cmd.first   = item_data.msg_class;
        push.cmd.second  = item_data.msg_id;
        push.cmd.length  = item_data.payload_length;
        push.cmd.ck_a    = hdr_a4;
        push.cmd.ck_b    = hdr_b;
        push.cmd.tail    = len_zero;
        if (take)
        begin
            if (item_data.op == ubx_pkg::OP_START)
            begin
                push.valid    = 1'b1;
                sum_a_next    = hdr_a4;
                sum_b_next    = hdr_b;
                left_next     = item_data.payload_length;
                in_frame_next = !len_zero;
            end
            else if (in_frame_reg)
            begin
                push.valid      = 1'b1;
                push.cmd.kind   = ubx_pkg::KIND_DATA;
                push.cmd.first  = item_data.payload_byte;
                push.cmd.ck_a   = dat_a;
                push.cmd.ck_b   = dat_b;
                push.cmd.tail   = last_byte;
                sum_a_next      = dat_a;
                sum_b_next      = dat_b;
                left_next       = left_reg - 16'd1;
                in_frame_next   = !last_byte;
            end
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_a_reg    <= 8'd0;
            sum_b_reg    <= 8'd0;
            left_reg     <= 16'd0;
            in_frame_reg <= 1'b0;
        end
        else
        begin
            sum_a_reg    <= sum_a_next;
            sum_b_reg    <= sum_b_next;
            left_reg     <= left_next;
            in_frame_reg <= in_frame_next;
        end
    end

`ifndef SYNTH
    // The frame flag and the remaining count always agree.
    a_frame_count: assert property (@(posedge clk) disable iff (!rst_n)
        in_frame_reg == (left_reg != 16'd0))
        else $error("frame flag and remaining byte count disagree");
`endif

endmodule

### rtl/core/ubx_queue.sv
// ----------------------------------------------------------------------------
// ubx_queue
// Small command queue between the front end and the serializer, so that each
// side can stall on its own.
// ----------------------------------------------------------------------------
module ubx_queue #(
    parameter int DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ubx_pkg::ubx_push_t push,
    output logic               full,
    output logic               head_valid,
    output ubx_pkg::ubx_cmd_t  head,
    input  logic               pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ubx_pkg::ubx_cmd_t entry_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        count_next = count_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.cmd;
        end
    end

`ifndef SYNTH
    // The front end never offers a command to a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> !full)
        else $error("command pushed into a full queue");

    // The fill count never exceeds the depth.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue fill count out of range");
`endif

endmodule

### rtl/core/ubx_back.sv
// ----------------------------------------------------------------------------
// ubx_back
// Back end: serializes the queue's head command into frame bytes, one byte
// per cycle while frame_ready is high, through a registered output stage.
// ----------------------------------------------------------------------------
module ubx_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  ubx_pkg::ubx_cmd_t head,
    output logic              pop,
    output logic              frame_valid,
    input  logic              frame_ready,
    output ubx_pkg::ubx_out_t frame_data
);

    // Byte positions within a header command.
    localparam logic [2:0] HDR_SYNC_ONE = 3'd0;
    localparam logic [2:0] HDR_SYNC_TWO = 3'd1;
    localparam logic [2:0] HDR_CLASS    = 3'd2;
    localparam logic [2:0] HDR_ID       = 3'd3;
    localparam logic [2:0] HDR_LEN_LO   = 3'd4;
    localparam logic [2:0] HDR_LEN_HI   = 3'd5;
    localparam logic [2:0] HDR_CK_A     = 3'd6;
    localparam logic [2:0] HDR_CK_B     = 3'd7;

    // Byte positions within a data command.
    localparam logic [2:0] DAT_BYTE     = 3'd0;
    localparam logic [2:0] DAT_CK_A     = 3'd1;
    localparam logic [2:0] DAT_CK_B     = 3'd2;

    logic [2:0]        idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    ubx_pkg::ubx_out_t out_reg;
    ubx_pkg::ubx_out_t sel;
    logic [2:0]        last_idx;
    logic              take;
    logic              at_last;

    assign frame_valid = out_valid_reg;
    assign frame_data  = out_reg;

    // Byte selection for the current position.
    always_comb
    begin
        sel.out_byte  = head.first;
        sel.frame_end = 1'b0;
        if (head.kind == ubx_pkg::KIND_HEADER)
        begin
            last_idx = head.tail ? HDR_CK_B : HDR_LEN_HI;
            case (idx_reg)
                HDR_SYNC_ONE: sel.out_byte = ubx_pkg::SYNC_ONE;
                HDR_SYNC_TWO: sel.out_byte = ubx_pkg::SYNC_TWO;
                HDR_CLASS:    sel.out_byte = head.first;
                HDR_ID:       sel.out_byte = head.second;
                HDR_LEN_LO:   sel.out_byte = head.length[7:0];
                HDR_LEN_HI:   sel.out_byte = head.length[15:8];
                HDR_CK_A:     sel.out_byte = head.ck_a;
                HDR_CK_B:
                begin
                    sel.out_byte  = head.ck_b;
                    sel.frame_end = 1'b1;
                end
                default:      sel.out_byte = head.first;
            endcase
        end
        else
        begin
            last_idx = head.tail ? DAT_CK_B : DAT_BYTE;
            case (idx_reg)
                DAT_BYTE:     sel.out_byte = head.first;
                DAT_CK_A:     sel.out_byte = head.ck_a;
                DAT_CK_B:
                begin
                    sel.out_byte  = head.ck_b;
                    sel.frame_end = 1'b1;
                end
                default:      sel.out_byte = head.first;
            endcase
        end
    end

    // Advance when the output stage is empty or being drained.
    assign take    = head_valid && (!out_valid_reg || frame_ready);
    assign at_last = (idx_reg == last_idx);
    assign pop     = take && at_last;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !frame_ready;
        if (take)
        begin
            idx_next       = at_last ? 3'd0 : idx_reg + 3'd1;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output data register.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg <= sel;
        end
    end

`ifndef SYNTH
    // A command in progress stays at the head of the queue until finished.
    a_busy_head: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != 3'd0) |-> head_valid)
        else $error("serializer mid-command with an empty queue");
`endif

endmodule

### rtl/core/ubx_frame_builder.sv
// ----------------------------------------------------------------------------
// ubx_frame_builder
// UBX frame serializer with 8-bit Fletcher checksum: a front end that takes
// input items, a command queue, and a byte-wide back end.
// ----------------------------------------------------------------------------
// Each accepted item becomes at most one queued command, and the serializer
// emits one byte per cycle from it while frame_ready is high: a start item
// yields six bytes (sync, class, id, length low and high), or eight with both
// checksum bytes when the length is zero; a payload byte yields one byte, or
// three when it ends the frame. The input side takes one item per cycle as
// long as the queue (QUEUE_DEPTH commands) has room, so sustained payload
// streaming runs at one item per cycle, and the single-byte output register
// sets the pace during header and checksum bursts. A start during a frame
// abandons it without checksum bytes; payload items outside a frame are taken
// and dropped. frame_end marks each completed frame's last checksum byte.
// ----------------------------------------------------------------------------
module ubx_frame_builder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  ubx_pkg::ubx_in_t  item_data,
    output logic              frame_valid,
    input  logic              frame_ready,
    output ubx_pkg::ubx_out_t frame_data
);

    ubx_pkg::ubx_push_t push;
    ubx_pkg::ubx_cmd_t  head;
    logic               q_full;
    logic               head_valid;
    logic               pop;

    ubx_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item_data  (item_data),
        .q_full     (q_full),
        .push       (push)
    );

    ubx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    ubx_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head        (head),
        .pop         (pop),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame_data  (frame_data)
    );

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the UBX frame builder. A send task drives input
// transfers and updates a frame model. The model queues the bytes that each
// accepted item should produce, together with the running Fletcher checksum.
// A monitor compares every accepted output transfer with the oldest queued
// byte. Directed tests cover zero-length frames, payload bytes while no
// frame is open, short frames, abandoned frames and a longer streamed frame.
// A random test then mixes well-formed frames with noise and broken frames.
// Both sides insert random idle gaps.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              item_valid;
    logic              item_ready;
    ubx_pkg::ubx_in_t  item_data;
    logic              frame_valid;
    logic              frame_ready;
    ubx_pkg::ubx_out_t frame_data;

    // Frame model state.
    logic [7:0]  run_ck_a;
    logic [7:0]  run_ck_b;
    logic [15:0] bytes_due;
    logic        frame_open;

    // Bytes that the model expects, oldest first.
    ubx_pkg::ubx_out_t frame_bytes_due[$];
    ubx_pkg::ubx_out_t oldest_byte;

    int  errors      = 0;
    int  items_taken = 0;
    int  stall_left  = 0;
    bit  quiet       = 1'b0;

    ubx_frame_builder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item_data   (item_data),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame_data  (frame_data)
    );

    always #2 clk = ~clk;

    // Idle lengths: mostly short, a few long.
    function automatic int idle_length();
        if ($urandom_range(0, 9) < 8)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic int sender_gap();
        if (quiet || $urandom_range(0, 99) < 60)
        begin
            return 0;
        end
        return idle_length();
    endfunction

    // Queue one expected byte.
    task automatic push_byte(input logic [7:0] value, input logic last);
        ubx_pkg::ubx_out_t b;
        b.out_byte  = value;
        b.frame_end = last;
        frame_bytes_due.push_back(b);
    endtask

    // Add one byte to both running checksum sums.
    task automatic add_to_checksum(input logic [7:0] value);
        run_ck_a = run_ck_a + value;
        run_ck_b = run_ck_b + run_ck_a;
    endtask

    // Frame model: work out the bytes that one accepted item produces.
    task automatic predict_frame(input ubx_pkg::ubx_in_t it);
        if (it.op == ubx_pkg::OP_START)
        begin
            run_ck_a = 8'h00;
            run_ck_b = 8'h00;
            add_to_checksum(it.msg_class);
            add_to_checksum(it.msg_id);
            add_to_checksum(it.payload_length[7:0]);
            add_to_checksum(it.payload_length[15:8]);
            push_byte(ubx_pkg::SYNC_ONE, 1'b0);
            push_byte(ubx_pkg::SYNC_TWO, 1'b0);
            push_byte(it.msg_class, 1'b0);
            push_byte(it.msg_id, 1'b0);
            push_byte(it.payload_length[7:0], 1'b0);
            push_byte(it.payload_length[15:8], 1'b0);
            bytes_due  = it.payload_length;
            frame_open = (it.payload_length != 16'd0);
            if (it.payload_length == 16'd0)
            begin
                push_byte(run_ck_a, 1'b0);
                push_byte(run_ck_b, 1'b1);
            end
        end
        else if (frame_open)
        begin
            add_to_checksum(it.payload_byte);
            push_byte(it.payload_byte, 1'b0);
            bytes_due = bytes_due - 16'd1;
            if (bytes_due == 16'd0)
            begin
                push_byte(run_ck_a, 1'b0);
                push_byte(run_ck_b, 1'b1);
                frame_open = 1'b0;
            end
        end
    endtask

    // Send one item. Valid stays high across back-to-back transfers.
    task automatic send_item(input ubx_pkg::ubx_in_t it);
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item_data  <= it;
        do
        begin
            @(posedge clk);
        end
        while (!item_ready);
        if (it.op == ubx_pkg::OP_START || frame_open)
        begin
            items_taken++;
        end
        predict_frame(it);
    endtask

    function automatic ubx_pkg::ubx_in_t start_item(input logic [7:0] cls,
                                                    input logic [7:0] id,
                                                    input logic [15:0] len);
        ubx_pkg::ubx_in_t it;
        it.op             = ubx_pkg::OP_START;
        it.msg_class      = cls;
        it.msg_id         = id;
        it.payload_length = len;
        it.payload_byte   = 8'($urandom());
        return it;
    endfunction

    function automatic ubx_pkg::ubx_in_t payload_item(input logic [7:0] value);
        ubx_pkg::ubx_in_t it;
        it.op             = ubx_pkg::OP_PAYLOAD;
        it.msg_class      = 8'($urandom());
        it.msg_id         = 8'($urandom());
        it.payload_length = 16'($urandom());
        it.payload_byte   = value;
        return it;
    endfunction

    // Hold the input side idle until every expected byte has arrived.
    task automatic drain_frames();
        item_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (frame_bytes_due.size() != 0);
    endtask

    // A zero-length start yields the header and both checksum bytes at once.
    task automatic test_zero_length();
        send_item(start_item(8'h00, 8'h00, 16'h0000));
        send_item(start_item(8'hFF, 8'hFF, 16'h0000));
        drain_frames();
    endtask

    // Payload bytes with no open frame are dropped.
    task automatic test_idle_payload();
        send_item(payload_item(8'h00));
        send_item(payload_item(8'hFF));
        send_item(start_item(8'h01, 8'h02, 16'h0001));
        send_item(payload_item(8'h5A));
        send_item(payload_item(8'hA5));
        drain_frames();
    endtask

    // Short frames with extreme payload bytes.
    task automatic test_short_frames();
        send_item(start_item(8'h06, 8'h01, 16'h0002));
        send_item(payload_item(8'hFF));
        send_item(payload_item(8'hFF));
        send_item(start_item(8'hFF, 8'h00, 16'h0003));
        send_item(payload_item(8'h00));
        send_item(payload_item(8'h80));
        send_item(payload_item(8'h7F));
        drain_frames();
    endtask

    // A start during a frame abandons it without checksum bytes.
    task automatic test_abandon();
        send_item(start_item(8'h0A, 8'h0B, 16'hFF00));
        send_item(payload_item(8'h11));
        send_item(payload_item(8'h22));
        send_item(start_item(8'h05, 8'h01, 16'h0001));
        send_item(payload_item(8'h33));
        send_item(start_item(8'hC3, 8'h3C, 16'hABCD));
        send_item(start_item(8'h27, 8'h72, 16'h0000));
        drain_frames();
    endtask

    // The checksum must cover every byte of a longer streamed payload.
    task automatic test_long_frame();
        int i;
        quiet = 1'b1;
        send_item(start_item(8'h0D, 8'h01, 16'h0040));
        for (i = 0; i < 64; i++)
        begin
            send_item(payload_item(8'($urandom())));
        end
        drain_frames();
        quiet = 1'b0;
    endtask

    // Mostly well-formed frames, with idle noise and broken frames mixed in.
    task automatic test_random_frames();
        int target;
        int r;
        int len;
        int i;
        target = items_taken + 100;
        while (items_taken < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                len = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 6) : $urandom_range(7, 40);
                send_item(start_item(8'($urandom()), 8'($urandom()), 16'(len)));
                for (i = 0; i < len; i++)
                begin
                    send_item(payload_item(8'($urandom())));
                end
            end
            else if (r < 80)
            begin
                repeat ($urandom_range(1, 3)) send_item(payload_item(8'($urandom())));
            end
            else if (r < 95)
            begin
                send_item(start_item(8'($urandom()), 8'($urandom()), 16'($urandom())));
                repeat ($urandom_range(0, 4)) send_item(payload_item(8'($urandom())));
            end
            else
            begin
                quiet = ~quiet;
                if (r >= 98)
                begin
                    drain_frames();
                end
            end
        end
        quiet = 1'b0;
    endtask

    // Receiver: random stalls, unless a quiet stretch is running.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            frame_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end
        else if (!quiet && $urandom_range(0, 3) == 0)
        begin
            frame_ready <= 1'b0;
            stall_left  <= idle_length() - 1;
        end
        else
        begin
            frame_ready <= 1'b1;
        end
    end

    // Compare every output transfer with the oldest expected byte.
    always @(posedge clk)
    begin
        if (rst_n && frame_valid && frame_ready)
        begin
            if (frame_bytes_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected transfer, expected none, actual byte %02h end %0b",
                         $time, frame_data.out_byte, frame_data.frame_end);
            end
            else
            begin
                oldest_byte = frame_bytes_due.pop_front();
                if (frame_data.out_byte !== oldest_byte.out_byte)
                begin
                    errors++;
                    $display("%0t: out_byte expected %02h actual %02h",
                             $time, oldest_byte.out_byte, frame_data.out_byte);
                end
                if (frame_data.frame_end !== oldest_byte.frame_end)
                begin
                    errors++;
                    $display("%0t: frame_end expected %0b actual %0b",
                             $time, oldest_byte.frame_end, frame_data.frame_end);
                end
            end
        end
    end

    // Main sequence.
    initial
    begin
        rst_n       <= 1'b0;
        item_valid  <= 1'b0;
        item_data   <= '0;
        frame_ready <= 1'b0;
        run_ck_a    = 8'h00;
        run_ck_b    = 8'h00;
        bytes_due   = 16'd0;
        frame_open  = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_length();
        test_idle_payload();
        test_short_frames();
        test_abandon();
        test_long_frame();
        test_random_frames();

        drain_frames();
        repeat (20) @(posedge clk);
        if (frame_bytes_due.size() != 0)
        begin
            errors++;
            $display("%0t: %0d expected bytes never arrived", $time, frame_bytes_due.size());
        end
        if (errors == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog.
    initial
    begin
        #2400000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### filelist.f
rtl/core/ubx_pkg.sv
rtl/core/ubx_front.sv
rtl/core/ubx_queue.sv
rtl/core/ubx_back.sv
rtl/core/ubx_frame_builder.sv
tb/tb.sv
